// File: design/cna_pkg.sv
// Shared types and constants for the complex number ALU.
`timescale 1ns / 1ps

package cna_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int RESULT_WIDTH      = 32;
    localparam int KIND_WIDTH        = 3;
    localparam int STATUS_WIDTH      = 2;

    typedef enum logic [KIND_WIDTH-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

endpackage

// File: design/cna_in_if.sv
// Command channel: operation code and two complex operands.
`timescale 1ns / 1ps

interface cna_in_if #(
    parameter int OPERAND_WIDTH = cna_pkg::OPERAND_WIDTH_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic [cna_pkg::KIND_WIDTH-1:0]      kind;
    logic signed [OPERAND_WIDTH-1:0]     first_real;
    logic signed [OPERAND_WIDTH-1:0]     first_imag;
    logic signed [OPERAND_WIDTH-1:0]     second_real;
    logic signed [OPERAND_WIDTH-1:0]     second_imag;

    modport source (
        output valid, kind, first_real, first_imag, second_real, second_imag,
        input  ready
    );
    modport sink (
        input  valid, kind, first_real, first_imag, second_real, second_imag,
        output ready
    );
endinterface

// File: design/cna_out_if.sv
// Response channel: complex result and status.
`timescale 1ns / 1ps

interface cna_out_if ();
    logic                                    valid;
    logic                                    ready;
    logic signed [cna_pkg::RESULT_WIDTH-1:0] result_real;
    logic signed [cna_pkg::RESULT_WIDTH-1:0] result_imag;
    logic [cna_pkg::STATUS_WIDTH-1:0]        status;

    modport source (
        output valid, result_real, result_imag, status,
        input  ready
    );
    modport sink (
        input  valid, result_real, result_imag, status,
        output ready
    );
endinterface

// File: design/complex_number_alu.sv
// Pipelined fixed-point complex ALU: add, subtract, multiply, divide, magnitude.
//
// Every operation goes through the same pipeline, so results leave in the order
// the commands came in, and a new beat is taken on every cycle while the skid
// entry is empty. The pipeline has one multiplier stage, one setup stage, one
// restoring-division stage per quotient bit (the square root uses the first
// half of those stages, one root bit each), and the output register. A
// two-entry output buffer lets the pipeline keep its beat while a result
// waits; the pipeline halts only once both entries are full.
`timescale 1ns / 1ps

module complex_number_alu #(
    parameter int OPERAND_WIDTH = cna_pkg::OPERAND_WIDTH_DEF,
    parameter int FRACTION_BITS = cna_pkg::FRACTION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cna_in_if.sink     cmd,
    cna_out_if.source  rsp
);

    localparam int W      = OPERAND_WIDTH;
    localparam int F      = FRACTION_BITS;
    localparam int RW     = cna_pkg::RESULT_WIDTH;
    localparam int PW     = 2 * W;
    localparam int NUM_W  = 2 * W + 2 * F;
    localparam int RAD_W  = 2 * W + 2 * F;
    localparam int SQ_W   = W + F;
    localparam int EW     = 2 * W + F + 34;

    localparam logic signed [EW-1:0] SMAX = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] SMIN = EW'(-64'sd2147483648);

    typedef struct packed {
        cna_pkg::op_t            op;
        logic signed [RW-1:0]    simple_re;
        logic signed [RW-1:0]    simple_im;
        logic                    simple_sat;
        logic                    neg_re;
        logic                    neg_im;
        logic                    den_zero;
        logic [NUM_W-1:0]        n_re;
        logic [NUM_W-1:0]        n_im;
        logic [PW-1:0]           r_re;
        logic [PW-1:0]           r_im;
        logic [PW-1:0]           den;
        logic [RAD_W-1:0]        x;
        logic [SQ_W+1:0]         sr;
        logic [SQ_W-1:0]         q;
    } stage_t;

    function automatic logic is_sat(input logic signed [EW-1:0] v);
        return (v > SMAX) || (v < SMIN);
    endfunction

    function automatic logic signed [RW-1:0] clamp(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        c = v;
        if (v > SMAX)
            c = SMAX;
        else if (v < SMIN)
            c = SMIN;
        return c[RW-1:0];
    endfunction

    logic en;
    logic skid_valid_reg;

    assign en        = !skid_valid_reg;
    assign cmd.ready = en;

    // Stage A: operands and all products
    logic                       pa_valid_reg;
    cna_pkg::op_t               pa_op_reg;
    logic signed [W-1:0]        pa_ar_reg, pa_ai_reg, pa_br_reg, pa_bi_reg;
    logic signed [PW-1:0]       p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PW-1:0]       p4_reg, p5_reg, p6_reg, p7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pa_valid_reg <= 1'b0;
        else if (en)
            pa_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_op_reg <= cna_pkg::op_t'(cmd.kind);
            pa_ar_reg <= cmd.first_real;
            pa_ai_reg <= cmd.first_imag;
            pa_br_reg <= cmd.second_real;
            pa_bi_reg <= cmd.second_imag;
            p0_reg    <= cmd.first_real  * cmd.second_real;
            p1_reg    <= cmd.first_imag  * cmd.second_imag;
            p2_reg    <= cmd.first_real  * cmd.second_imag;
            p3_reg    <= cmd.second_real * cmd.first_imag;
            p4_reg    <= cmd.second_real * cmd.second_real;
            p5_reg    <= cmd.second_imag * cmd.second_imag;
            p6_reg    <= cmd.first_real  * cmd.first_real;
            p7_reg    <= cmd.first_imag  * cmd.first_imag;
        end
    end

    // Stage B setup, then one iteration stage per quotient bit
    logic   st_valid_reg [NUM_W+1];
    stage_t st_reg       [NUM_W+1];
    stage_t st_next      [NUM_W+1];

    always_comb
    begin
        logic signed [EW-1:0] re_e;
        logic signed [EW-1:0] im_e;
        logic signed [EW-1:0] nr;
        logic signed [EW-1:0] ni;
        logic signed [EW-1:0] mag_r;
        logic signed [EW-1:0] mag_i;
        logic [PW-1:0]        s;

        re_e = '0;
        im_e = '0;
        case (pa_op_reg)
            cna_pkg::OP_ADD:
            begin
                re_e = (EW'(pa_ar_reg) + EW'(pa_br_reg)) <<< F;
                im_e = (EW'(pa_ai_reg) + EW'(pa_bi_reg)) <<< F;
            end
            cna_pkg::OP_SUB:
            begin
                re_e = (EW'(pa_ar_reg) - EW'(pa_br_reg)) <<< F;
                im_e = (EW'(pa_ai_reg) - EW'(pa_bi_reg)) <<< F;
            end
            cna_pkg::OP_MUL:
            begin
                re_e = EW'(p0_reg) - EW'(p1_reg);
                im_e = EW'(p2_reg) + EW'(p3_reg);
            end
            default:
            begin
                re_e = '0;
                im_e = '0;
            end
        endcase

        nr    = EW'(p0_reg) + EW'(p1_reg);
        ni    = EW'(p3_reg) - EW'(p2_reg);
        mag_r = (nr < 0) ? -nr : nr;
        mag_i = (ni < 0) ? -ni : ni;
        s     = $unsigned(p6_reg) + $unsigned(p7_reg);

        st_next[0].op         = pa_op_reg;
        st_next[0].simple_re  = clamp(re_e);
        st_next[0].simple_im  = clamp(im_e);
        st_next[0].simple_sat = is_sat(re_e) || is_sat(im_e);
        st_next[0].neg_re     = nr < 0;
        st_next[0].neg_im     = ni < 0;
        st_next[0].den        = $unsigned(p4_reg) + $unsigned(p5_reg);
        st_next[0].den_zero   = (p4_reg == '0) && (p5_reg == '0);
        st_next[0].n_re       = NUM_W'(mag_r[PW-1:0]) << (2 * F);
        st_next[0].n_im       = NUM_W'(mag_i[PW-1:0]) << (2 * F);
        st_next[0].r_re       = '0;
        st_next[0].r_im       = '0;
        st_next[0].x          = RAD_W'(s) << (2 * F);
        st_next[0].sr         = '0;
        st_next[0].q          = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg[0] <= 1'b0;
        else if (en)
            st_valid_reg[0] <= pa_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg[0] <= st_next[0];
    end

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_iter
        always_comb
        begin
            logic [PW:0]     rem_re;
            logic [PW:0]     rem_im;
            logic [PW:0]     dif_re;
            logic [PW:0]     dif_im;
            logic [SQ_W+3:0] rr;
            logic [SQ_W+3:0] trial;
            logic [SQ_W+3:0] dif_sq;

            st_next[k+1] = st_reg[k];

            // one restoring-division bit for each part
            rem_re = {st_reg[k].r_re, st_reg[k].n_re[NUM_W-1]};
            rem_im = {st_reg[k].r_im, st_reg[k].n_im[NUM_W-1]};
            dif_re = rem_re - {1'b0, st_reg[k].den};
            dif_im = rem_im - {1'b0, st_reg[k].den};
            if (rem_re >= {1'b0, st_reg[k].den})
            begin
                st_next[k+1].r_re = dif_re[PW-1:0];
                st_next[k+1].n_re = {st_reg[k].n_re[NUM_W-2:0], 1'b1};
            end
            else
            begin
                st_next[k+1].r_re = rem_re[PW-1:0];
                st_next[k+1].n_re = {st_reg[k].n_re[NUM_W-2:0], 1'b0};
            end
            if (rem_im >= {1'b0, st_reg[k].den})
            begin
                st_next[k+1].r_im = dif_im[PW-1:0];
                st_next[k+1].n_im = {st_reg[k].n_im[NUM_W-2:0], 1'b1};
            end
            else
            begin
                st_next[k+1].r_im = rem_im[PW-1:0];
                st_next[k+1].n_im = {st_reg[k].n_im[NUM_W-2:0], 1'b0};
            end

            // one square-root bit while root bits remain; hold afterwards
            rr     = {st_reg[k].sr, st_reg[k].x[RAD_W-1 -: 2]};
            trial  = {2'b00, st_reg[k].q, 2'b01};
            dif_sq = rr - trial;
            if (k < SQ_W)
            begin
                st_next[k+1].x = {st_reg[k].x[RAD_W-3:0], 2'b00};
                if (rr >= trial)
                begin
                    st_next[k+1].sr = dif_sq[SQ_W+1:0];
                    st_next[k+1].q  = {st_reg[k].q[SQ_W-2:0], 1'b1};
                end
                else
                begin
                    st_next[k+1].sr = rr[SQ_W+1:0];
                    st_next[k+1].q  = {st_reg[k].q[SQ_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[k+1] <= 1'b0;
            else if (en)
                st_valid_reg[k+1] <= st_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k+1] <= st_next[k+1];
        end
    end

    // Final result selection
    logic signed [RW-1:0]      fin_re;
    logic signed [RW-1:0]      fin_im;
    cna_pkg::status_t          fin_status;

    always_comb
    begin
        logic signed [EW-1:0] qr;
        logic signed [EW-1:0] qi;
        logic signed [EW-1:0] root;
        logic                 sat;

        qr   = EW'(st_reg[NUM_W].n_re);
        qi   = EW'(st_reg[NUM_W].n_im);
        if (st_reg[NUM_W].neg_re)
            qr = -qr;
        if (st_reg[NUM_W].neg_im)
            qi = -qi;
        root = EW'(st_reg[NUM_W].q);

        sat        = 1'b0;
        fin_re     = '0;
        fin_im     = '0;
        fin_status = cna_pkg::ST_OK;
        unique case (st_reg[NUM_W].op)
            cna_pkg::OP_ADD, cna_pkg::OP_SUB, cna_pkg::OP_MUL:
            begin
                fin_re = st_reg[NUM_W].simple_re;
                fin_im = st_reg[NUM_W].simple_im;
                sat    = st_reg[NUM_W].simple_sat;
            end
            cna_pkg::OP_DIV:
            begin
                if (!st_reg[NUM_W].den_zero)
                begin
                    fin_re = clamp(qr);
                    fin_im = clamp(qi);
                    sat    = is_sat(qr) || is_sat(qi);
                end
            end
            cna_pkg::OP_MAG:
            begin
                fin_re = clamp(root);
                sat    = is_sat(root);
            end
            default:
            begin
                fin_re = '0;
                fin_im = '0;
            end
        endcase

        if (st_reg[NUM_W].op == cna_pkg::OP_DIV && st_reg[NUM_W].den_zero)
            fin_status = cna_pkg::ST_DIV0;
        else if (sat)
            fin_status = cna_pkg::ST_SAT;
    end

    // Output register plus skid entry
    logic                  out_valid_reg;
    logic signed [RW-1:0]  out_re_reg, out_im_reg, skid_re_reg, skid_im_reg;
    cna_pkg::status_t      out_status_reg, skid_status_reg;
    logic                  pipe_out;
    logic                  out_free;

    assign pipe_out = en && st_valid_reg[NUM_W];
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || pipe_out;
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_out)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_re_reg     <= skid_re_reg;
                out_im_reg     <= skid_im_reg;
                out_status_reg <= skid_status_reg;
            end
            else
            begin
                out_re_reg     <= fin_re;
                out_im_reg     <= fin_im;
                out_status_reg <= fin_status;
            end
        end
        else if (pipe_out)
        begin
            skid_re_reg     <= fin_re;
            skid_im_reg     <= fin_im;
            skid_status_reg <= fin_status;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_real = out_re_reg;
    assign rsp.result_imag = out_im_reg;
    assign rsp.status      = out_status_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(rsp.valid && !rsp.ready))
        else $error("skid entry filled without an output stall");

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == cna_pkg::ST_DIV0)
            |-> (rsp.result_real == '0 && rsp.result_imag == '0))
        else $error("divide-by-zero beat carries a nonzero result");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == cna_pkg::ST_SAT)
            |-> (rsp.result_real == SMAX[RW-1:0] || rsp.result_real == SMIN[RW-1:0]
                 || rsp.result_imag == SMAX[RW-1:0] || rsp.result_imag == SMIN[RW-1:0]))
        else $error("saturated beat has no part at a bound");

endmodule
